// ===== src/humidity_temperature_frame_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame decoder core
// Shared forms for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HTFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 step for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd12500;
    localparam logic [13:0] HUM_OFFSET  = 14'd600;
    localparam logic [13:0] HUM_MAX     = 14'd10000;
    localparam logic [13:0] HUM_TOP     = 14'd10600;

    // Position of the next expected byte within the frame
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    // One byte through the CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/htfd_in_if.sv =====
// ----------------------------------------------------------------------------
// htfd_in_if
// Byte channel into the frame decoder: one frame byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== src/htfd_out_if.sv =====
// ----------------------------------------------------------------------------
// htfd_out_if
// Result channel out of the frame decoder: one decoded sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic               sample_valid;
    logic               temp_crc_error;
    logic               humid_crc_error;
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;

    modport source (output valid, output sample_valid, output temp_crc_error,
                    output humid_crc_error, output temperature_centi,
                    output humidity_centi, input ready);
    modport sink   (input valid, input sample_valid, input temp_crc_error,
                    input humid_crc_error, input temperature_centi,
                    input humidity_centi, output ready);
endinterface

`default_nettype wire

// ===== src/humidity_temperature_frame_decoder_core.sv =====
// Throughput: one byte word per cycle, with no gaps between frames; the input
//   stalls only while a product word waits behind an unread result word.
// A frame's sixth byte passes the input register, then the product register,
//   then the result register before the result word is shown.
// The constant multipliers and their divide-by-65535 correction set the depth.
// Reset: synchronous, active low; clears the frame position, the CRC to 0xFF,
//   the temperature check flag and the stage valid bits. Data words are not reset.
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_core
// Decodes six-byte sensor frames (T_hi, T_lo, T_crc, H_hi, H_lo, H_crc),
// checks each data word with CRC-8 (poly 0x31, init 0xFF) and converts the
// raw words to centidegrees and centipercent.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temperature_frame_decoder_core_assert.svh"

module humidity_temperature_frame_decoder_core
    import htfd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    htfd_in_if.sink     i_in,
    htfd_out_if.source  o_out
);

    // Result advance: the result register is empty or its word is being read
    logic w_res_adv;
    // Front advance: input, frame state and product move unless a product
    // word waits behind an unread result
    logic w_adv;

    // Stage 0: input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Frame state
    t_pos        r_pos,    n_pos;
    logic [7:0]  r_crc,    n_crc;
    logic [15:0] r_t_word, n_t_word;
    logic [15:0] r_h_word, n_h_word;
    logic        r_t_fail, n_t_fail;

    // Stage 1: product register
    logic        r_mul_valid;
    logic [30:0] r_t_prod;
    logic [29:0] r_h_prod;
    logic        r_t_err;
    logic        r_h_err;

    // Stage 2: result register
    logic               r_res_valid;
    logic               r_sample_valid;
    logic               r_temp_err;
    logic               r_humid_err;
    logic signed [14:0] r_temp;
    logic        [13:0] r_humid;

    // Decode helpers
    t_pos        w_pos_eff;
    logic [7:0]  w_crc_eff;
    logic        w_last;
    logic        w_h_bad;

    logic [31:0] w_t_sum;
    logic [30:0] w_h_sum;
    logic [14:0] w_t_q;
    logic [13:0] w_h_q;
    logic [15:0] w_t_c;
    logic [13:0] w_h_c;
    logic        w_ok;

    // Refill the result register when empty or read; hold the front only
    // while the product register is full and cannot hand its word on
    assign w_res_adv  = !r_res_valid || o_out.ready;
    assign w_adv      = !r_mul_valid || w_res_adv;
    assign i_in.ready = w_adv;

    // ------------------------------------------------------------------
    // Stage 0: capture the byte word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_byte  <= i_in.data_byte;
            r_in_start <= i_in.frame_start;
        end
    end

    // ------------------------------------------------------------------
    // Frame tracking and CRC. A start mark drops any partial frame and
    // restarts the CRC; after the sixth byte the position wraps to T_hi.
    // ------------------------------------------------------------------
    always_comb begin
        w_pos_eff = r_in_start ? POS_T_HI : r_pos;
        w_crc_eff = r_in_start ? CRC_INIT : r_crc;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_t_word  = r_t_word;
        n_h_word  = r_h_word;
        n_t_fail  = r_t_fail;
        w_last    = 1'b0;
        w_h_bad   = 1'b0;
        if (r_in_valid) begin
            case (w_pos_eff)
                POS_T_LO: begin
                    n_crc         = crc8_byte(w_crc_eff, r_in_byte);
                    n_t_word[7:0] = r_in_byte;
                    n_pos         = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_t_fail = (w_crc_eff != r_in_byte);
                    n_crc    = CRC_INIT;
                    n_pos    = POS_H_HI;
                end
                POS_H_HI: begin
                    n_crc          = crc8_byte(CRC_INIT, r_in_byte);
                    n_h_word[15:8] = r_in_byte;
                    n_pos          = POS_H_LO;
                end
                POS_H_LO: begin
                    n_crc         = crc8_byte(w_crc_eff, r_in_byte);
                    n_h_word[7:0] = r_in_byte;
                    n_pos         = POS_H_CRC;
                end
                POS_H_CRC: begin
                    w_h_bad = (w_crc_eff != r_in_byte);
                    w_last  = 1'b1;
                    n_crc   = CRC_INIT;
                    n_pos   = POS_T_HI;
                end
                default: begin
                    // T_hi, and any position that cannot arise
                    n_crc          = crc8_byte(CRC_INIT, r_in_byte);
                    n_t_word[15:8] = r_in_byte;
                    n_pos          = POS_T_LO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_INIT;
            r_t_fail    <= 1'b0;
            r_mul_valid <= 1'b0;
        end else if (w_adv) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_t_fail    <= n_t_fail;
            r_mul_valid <= w_last;
        end
    end

    // Data words and products: payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_word <= n_t_word;
            r_h_word <= n_h_word;
            if (w_last) begin
                r_t_prod <= 31'(r_t_word) * 31'(TEMP_SCALE);
                r_h_prod <= 30'(r_h_word) * 30'(HUM_SCALE);
                r_t_err  <= r_t_fail;
                r_h_err  <= w_h_bad;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by 65535 as (p + (p >> 16) + 1) >> 16, exact for
    // p below 2^32 - 1, then subtract the offsets and clamp the humidity.
    // ------------------------------------------------------------------
    always_comb begin
        w_t_sum = 32'(r_t_prod) + 32'(r_t_prod >> 16) + 32'd1;
        w_h_sum = 31'(r_h_prod) + 31'(r_h_prod >> 16) + 31'd1;
        w_t_q   = w_t_sum[30:16];
        w_h_q   = w_h_sum[29:16];
        w_t_c   = 16'(w_t_q) - TEMP_OFFSET;
        if (w_h_q < HUM_OFFSET) begin
            w_h_c = '0;
        end else if (w_h_q > HUM_TOP) begin
            w_h_c = HUM_MAX;
        end else begin
            w_h_c = w_h_q - HUM_OFFSET;
        end
        w_ok = !r_t_err && !r_h_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_adv) begin
            r_res_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_adv && r_mul_valid) begin
            r_sample_valid <= w_ok;
            r_temp_err     <= r_t_err;
            r_humid_err    <= r_h_err;
            r_temp         <= w_ok ? $signed(w_t_c[14:0]) : 15'sd0;
            r_humid        <= w_ok ? w_h_c : 14'd0;
        end
    end

    assign o_out.valid             = r_res_valid;
    assign o_out.sample_valid      = r_sample_valid;
    assign o_out.temp_crc_error    = r_temp_err;
    assign o_out.humid_crc_error   = r_humid_err;
    assign o_out.temperature_centi = r_temp;
    assign o_out.humidity_centi    = r_humid;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `HTFD_ASSERT_NEXT(a_last_byte_makes_result, i_clk, i_rst_n,
        w_adv && r_in_valid && !r_in_start && r_pos == POS_H_CRC, r_mul_valid,
        "sixth byte did not produce a product word")
    `HTFD_ASSERT_NOW(a_valid_matches_flags, i_clk, i_rst_n, r_res_valid,
        r_sample_valid == !(r_temp_err || r_humid_err),
        "sample_valid disagrees with the CRC error flags")
    `HTFD_ASSERT_NOW(a_bad_sample_zeroed, i_clk, i_rst_n, r_res_valid && !r_sample_valid,
        r_temp == 15'sd0 && r_humid == 14'd0,
        "failed sample carries non-zero values")
    `HTFD_ASSERT_NOW(a_humidity_clamped, i_clk, i_rst_n, r_res_valid, r_humid <= HUM_MAX,
        "humidity above clamp limit")

endmodule

`default_nettype wire
